[hdl/min_tracking_stack_core_assert.svh]
// Assertion macros shared by the checker modules of the min-tracking stack.
`ifndef MIN_TRACKING_STACK_CORE_ASSERT_SVH
`define MIN_TRACKING_STACK_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define MTS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("min_tracking_stack_core: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define MTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("min_tracking_stack_core: next-cycle check failed");

`endif

[hdl/mts_pkg.sv]
// Shared constants, types and field layout of the min-tracking stack.
package mts_pkg;

	localparam int DEPTH   = 64;
	localparam int WIDTH   = 32;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DEPTH_W = 7;
	localparam int STAT_W  = 2;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// Result layout inside m_tdata, lowest bit first.
	localparam int TOP_LSB  = 0;
	localparam int MIN_LSB  = WIDTH;
	localparam int DEP_LSB  = 2 * WIDTH;
	localparam int EMP_BIT  = 2 * WIDTH + DEPTH_W;
	localparam int STAT_LSB = EMP_BIT + 1;
	localparam int OUT_W    = STAT_LSB + STAT_W;

	localparam int IN_TDATA_W  = ((WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	typedef logic signed [WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [ADDR_W-1:0]       addr_t;

	typedef struct packed {
		word_t min_val;
		word_t val;
	} entry_t;

endpackage

[hdl/mts_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
module mts_ram #(
	parameter int ADDR_W = 6,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/min_tracking_stack_core.sv]
// Top level of the min-tracking stack: control, top-of-stack cache and result register.
//
//   channel | direction | tdata (low bit first)                     | tuser
//   s_*     | in        | value                                     | op
//   m_*     | out       | top_value, min_value, depth, is_empty,    | -
//           |           | status                                    |
//
// A push, a refused push or pop, and a pop that empties the stack load the result
// register in the cycle they are accepted. A pop that leaves entries behind first reads
// the new top from the entry RAM, whose read data is registered, and loads it in ST_POP.
// Reset empties the stack at once; the RAM keeps its contents and needs no clearing.
// s_tready is low in ST_POP, while a pop waits for the new top from the RAM, and while
// a result waits in the output register and m_tready is low.
module min_tracking_stack_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mts_pkg::IN_TDATA_W-1:0]      s_tdata,  // value
	input  logic [0:0]                          s_tuser,  // op
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// top_value, min_value, depth, is_empty, status, zero padding
	output logic [mts_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_POP  = 1'b1;

	logic            state_q;
	mts_pkg::cnt_t   cnt_q;
	mts_pkg::word_t  top_val_q;
	mts_pkg::word_t  top_min_q;

	logic                          out_vld_q;
	mts_pkg::word_t                out_top_q;
	mts_pkg::word_t                out_min_q;
	logic [mts_pkg::DEPTH_W-1:0]   out_dep_q;
	logic                          out_emp_q;
	logic [mts_pkg::STAT_W-1:0]    out_stat_q;

	logic            acc;
	logic            op;
	mts_pkg::word_t  in_val;
	logic            cnt_full;
	logic            cnt_zero;
	mts_pkg::word_t  push_min;
	mts_pkg::cnt_t   cnt_m2;
	mts_pkg::entry_t wr_entry;
	mts_pkg::entry_t rd_entry;
	logic            ram_we;
	logic            ram_re;

	logic            nxt_state;
	mts_pkg::cnt_t   nxt_cnt;
	mts_pkg::word_t  nxt_top;
	mts_pkg::word_t  nxt_min;
	logic            out_load;
	logic [mts_pkg::STAT_W-1:0] nxt_stat;

	assign s_tready = (state_q == ST_IDLE) && (!out_vld_q || m_tready);
	assign acc      = s_tvalid && s_tready;
	assign op       = s_tuser[0];
	assign in_val   = s_tdata[mts_pkg::WIDTH-1:0];
	assign cnt_full = (cnt_q == mts_pkg::CNT_W'(mts_pkg::DEPTH));
	assign cnt_zero = (cnt_q == '0);
	assign cnt_m2   = cnt_q - mts_pkg::CNT_W'(2);

	// The running minimum only changes when the new value is strictly smaller.
	assign push_min = (!cnt_zero && !(in_val < top_min_q)) ? top_min_q : in_val;

	assign wr_entry.val     = in_val;
	assign wr_entry.min_val = push_min;

	always_comb begin
		nxt_state = state_q;
		nxt_cnt   = cnt_q;
		nxt_top   = top_val_q;
		nxt_min   = top_min_q;
		out_load  = 1'b0;
		nxt_stat  = mts_pkg::STAT_OK;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (op == mts_pkg::OP_PUSH) begin
						out_load = 1'b1;
						if (cnt_full) begin
							nxt_stat = mts_pkg::STAT_FULL;
						end else begin
							ram_we  = 1'b1;
							nxt_cnt = cnt_q + mts_pkg::CNT_W'(1);
							nxt_top = in_val;
							nxt_min = push_min;
						end
					end else begin
						if (cnt_zero) begin
							out_load = 1'b1;
							nxt_stat = mts_pkg::STAT_EMPTY;
						end else if (cnt_q == mts_pkg::CNT_W'(1)) begin
							out_load = 1'b1;
							nxt_cnt  = '0;
						end else begin
							// The entry below the top comes back from the RAM next cycle.
							ram_re    = 1'b1;
							nxt_cnt   = cnt_q - mts_pkg::CNT_W'(1);
							nxt_state = ST_POP;
						end
					end
				end
			end
			ST_POP: begin
				out_load  = 1'b1;
				nxt_top   = rd_entry.val;
				nxt_min   = rd_entry.min_val;
				nxt_state = ST_IDLE;
			end
			default: begin
				nxt_state = ST_IDLE;
			end
		endcase
	end

	mts_ram #(
		.ADDR_W (mts_pkg::ADDR_W),
		.DATA_W ($bits(mts_pkg::entry_t))
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[mts_pkg::ADDR_W-1:0]),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (cnt_m2[mts_pkg::ADDR_W-1:0]),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= nxt_state;
			cnt_q   <= nxt_cnt;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_val_q <= nxt_top;
		top_min_q <= nxt_min;
		if (out_load) begin
			out_top_q  <= (nxt_cnt == '0) ? '0 : nxt_top;
			out_min_q  <= (nxt_cnt == '0) ? '0 : nxt_min;
			out_dep_q  <= mts_pkg::DEPTH_W'(nxt_cnt);
			out_emp_q  <= (nxt_cnt == '0);
			out_stat_q <= nxt_stat;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = mts_pkg::OUT_TDATA_W'({out_stat_q, out_emp_q, out_dep_q,
		out_min_q, out_top_q});

endmodule

[hdl/mts_checker.sv]
// Port-level checker for the min-tracking stack, bound to its top level.
`include "min_tracking_stack_core_assert.svh"

module mts_port_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [mts_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	logic signed [mts_pkg::WIDTH-1:0] top_v;
	logic signed [mts_pkg::WIDTH-1:0] min_v;
	logic [mts_pkg::DEPTH_W-1:0]      dep_v;
	logic                             emp_v;
	logic [mts_pkg::STAT_W-1:0]       stat_v;
	logic                             dep_zero;
	logic                             dep_full;
	logic                             pop_refused;
	logic                             push_refused;

	assign top_v        = m_tdata[mts_pkg::TOP_LSB +: mts_pkg::WIDTH];
	assign min_v        = m_tdata[mts_pkg::MIN_LSB +: mts_pkg::WIDTH];
	assign dep_v        = m_tdata[mts_pkg::DEP_LSB +: mts_pkg::DEPTH_W];
	assign emp_v        = m_tdata[mts_pkg::EMP_BIT];
	assign stat_v       = m_tdata[mts_pkg::STAT_LSB +: mts_pkg::STAT_W];
	assign dep_zero     = (dep_v == '0);
	assign dep_full     = (dep_v == mts_pkg::DEPTH_W'(mts_pkg::DEPTH));
	assign pop_refused  = m_tvalid && (stat_v == mts_pkg::STAT_EMPTY);
	assign push_refused = m_tvalid && (stat_v == mts_pkg::STAT_FULL);

	// A refused pop can only report the empty stack.
	`MTS_ASSERT_IMPL(a_refused_pop_empty, pop_refused, emp_v && dep_zero)

	// An empty stack reports zero for both words.
	`MTS_ASSERT_IMPL(a_empty_zero, m_tvalid && emp_v, top_v == '0 && min_v == '0)

	// The tracked minimum never exceeds the value on top.
	`MTS_ASSERT_IMPL(a_min_le_top, m_tvalid && !emp_v, min_v <= top_v)

	// A refused push only happens at full depth.
	`MTS_ASSERT_IMPL(a_refused_push_full, push_refused, !emp_v && dep_full)

	// A stalled result holds until it is taken.
	`MTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind min_tracking_stack_core mts_port_checker u_mts_checker (.*);
